// ----- rtl/core/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, constants and helpers of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Width of the fraction fields that take part in the arithmetic.
  localparam int FIELD_WIDTH = 32;
  localparam int MAG_W       = FIELD_WIDTH;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int CNT_W       = $clog2(PROD_W);
  localparam int SHIFT_W     = $clog2(PROD_W + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Operation codes.
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIVZ = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } rau_out_t;

  // A classified job: three magnitude products with their signs.
  // Products 0 and 1 are summed for the numerator, product 2 is the denominator.
  typedef struct packed {
    logic                  err;
    logic [2:0][MAG_W-1:0] xm;
    logic [2:0][MAG_W-1:0] ym;
    logic [2:0]            ps;
  } rau_job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } rau_state_t;

  // Sign and magnitude of a field, sign-extended from bit FIELD_WIDTH-1.
  function automatic logic [MAG_W:0] decode(input logic [31:0] raw);
    logic [MAG_W-1:0] v;
    logic             neg;
    v   = raw[MAG_W-1:0];
    neg = v[MAG_W-1];
    return {neg, (neg ? (~v + 1'b1) : v)};
  endfunction

endpackage

// ----- rtl/core/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front
// Classifies an incoming word: error checks and selection of the products.
// ----------------------------------------------------------------------------
module rau_front (
  input  rau_pkg::rau_in_t  in_data,
  output rau_pkg::rau_job_t job
);
  import rau_pkg::*;

  logic [MAG_W:0]   an, ad, bn, bd;
  logic             bn_s;
  logic [MAG_W-1:0] one_m;

  assign an    = decode(in_data.a_num);
  assign ad    = decode(in_data.a_den);
  assign bn    = decode(in_data.b_num);
  assign bd    = decode(in_data.b_den);
  assign one_m = MAG_W'(1);

  // Subtraction flips the sign of the second numerator.
  assign bn_s = (in_data.cmd == CMD_SUB) ? ~bn[MAG_W] : bn[MAG_W];

  // Operand pairs for the three products, by operation.
  always_comb begin
    job.err = (ad[MAG_W-1:0] == '0) ||
              ((in_data.cmd inside {[CMD_ADD:CMD_DIV]}) && bd[MAG_W-1:0] == '0) ||
              ((in_data.cmd == CMD_DIV) && bn[MAG_W-1:0] == '0);
    job.xm  = '0;
    job.ym  = '0;
    job.ps  = '0;
    case (in_data.cmd)
      CMD_ADD, CMD_SUB: begin
        job.xm[0] = an[MAG_W-1:0]; job.ym[0] = bd[MAG_W-1:0];
        job.ps[0] = an[MAG_W] ^ bd[MAG_W];
        job.xm[1] = bn[MAG_W-1:0]; job.ym[1] = ad[MAG_W-1:0];
        job.ps[1] = bn_s ^ ad[MAG_W];
        job.xm[2] = ad[MAG_W-1:0]; job.ym[2] = bd[MAG_W-1:0];
        job.ps[2] = ad[MAG_W] ^ bd[MAG_W];
      end
      CMD_MUL: begin
        job.xm[0] = an[MAG_W-1:0]; job.ym[0] = bn[MAG_W-1:0];
        job.ps[0] = an[MAG_W] ^ bn[MAG_W];
        job.xm[2] = ad[MAG_W-1:0]; job.ym[2] = bd[MAG_W-1:0];
        job.ps[2] = ad[MAG_W] ^ bd[MAG_W];
      end
      CMD_DIV: begin
        job.xm[0] = an[MAG_W-1:0]; job.ym[0] = bd[MAG_W-1:0];
        job.ps[0] = an[MAG_W] ^ bd[MAG_W];
        job.xm[2] = ad[MAG_W-1:0]; job.ym[2] = bn[MAG_W-1:0];
        job.ps[2] = ad[MAG_W] ^ bn[MAG_W];
      end
      default: begin
        // Normalize, also for the unused codes.
        job.xm[0] = an[MAG_W-1:0]; job.ym[0] = one_m;
        job.ps[0] = an[MAG_W];
        job.xm[2] = ad[MAG_W-1:0]; job.ym[2] = one_m;
        job.ps[2] = ad[MAG_W];
      end
    endcase
  end

endmodule

// ----- rtl/core/rau_fifo.sv -----
// ----------------------------------------------------------------------------
// rau_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module rau_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rau_pkg::rau_job_t push_data,
  output logic              full,
  input  logic              pop,
  output rau_pkg::rau_job_t pop_data,
  output logic              empty
);
  import rau_pkg::*;

  rau_job_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = do_push ? ((wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count exceeds depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue fill count missed a push");

endmodule

// ----- rtl/core/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back
// Executes a job: products, signed sum, binary gcd, exact division, range check.
// ----------------------------------------------------------------------------
module rau_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  input  rau_pkg::rau_job_t  job_data,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rau_pkg::rau_out_t  out_data
);
  import rau_pkg::*;

  rau_state_t        st_r, st_nxt;
  rau_job_t          job_r, job_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic              s0_r, s0_nxt, s1_r, s1_nxt;
  logic [PROD_W-1:0] n_r, n_nxt, d_r, d_nxt;
  logic              ns_r, ns_nxt, ds_r, ds_nxt;
  logic [PROD_W-1:0] u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt, q_r, q_nxt;
  logic              ov_r, ov_nxt;
  rau_out_t          res_r, res_nxt;

  logic [PROD_W-1:0] prod;
  logic              prod_s;
  logic [PROD_W:0]   rem_sh;
  logic              q_bit;
  logic [PROD_W-1:0] half;
  logic              neg;
  logic              ovf;
  logic              div_last;
  logic              gcd_done;
  logic              out_free;

  assign out_free = !ov_r || out_ready;
  assign div_last = (cnt_r == CNT_W'(PROD_W - 1));
  assign gcd_done = (u_r == '0);
  assign half     = PROD_W'(1) << (FIELD_WIDTH - 1);

  // One magnitude product per cycle.
  always_comb begin
    prod   = job_r.xm[step_r] * job_r.ym[step_r];
    prod_s = job_r.ps[step_r] && (prod != '0);
  end

  // Restoring divider step, shared by both quotients.
  always_comb begin
    rem_sh = {rem_r, q_r[PROD_W-1]};
    q_bit  = (rem_sh >= {1'b0, g_r});
  end

  // Sign and range of the reduced result; n_r holds the numerator quotient.
  always_comb begin
    neg = (ns_r != ds_r) && (n_r != '0);
    ovf = (q_nxt > half - 1'b1) || (neg ? (n_r > half) : (n_r > half - 1'b1));
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (!job_empty) st_nxt = job_data.err ? S_FIN : S_MUL;
      S_MUL:  if (step_r == 2'd2) st_nxt = S_ADD;
      S_ADD:  st_nxt = S_GCD;
      S_GCD:  if (gcd_done) st_nxt = S_DIVN;
      S_DIVN: if (div_last) st_nxt = S_DIVD;
      S_DIVD: if (div_last) st_nxt = S_FIN;
      S_FIN:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    job_nxt  = job_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    s0_nxt   = s0_r;
    s1_nxt   = s1_r;
    n_nxt    = n_r;
    ns_nxt   = ns_r;
    d_nxt    = d_r;
    ds_nxt   = ds_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    q_nxt    = {q_r[PROD_W-2:0], q_bit};
    res_nxt  = res_r;
    ov_nxt   = ov_r && !out_ready;
    job_pop  = 1'b0;
    case (st_r)
      S_IDLE: begin
        job_pop  = !job_empty;
        job_nxt  = job_data;
        step_nxt = '0;
        res_nxt  = '{res_num: '0, res_den: '0, status: STAT_DIVZ};
      end
      S_MUL: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          2'd0:    begin p0_nxt = prod; s0_nxt = prod_s; end
          2'd1:    begin p1_nxt = prod; s1_nxt = prod_s; end
          default: begin d_nxt = prod; ds_nxt = prod_s; end
        endcase
      end
      S_ADD: begin
        // Signed-magnitude sum of the two numerator products.
        if (s0_r == s1_r) begin
          n_nxt = p0_r + p1_r; ns_nxt = s0_r;
        end else if (p0_r >= p1_r) begin
          n_nxt = p0_r - p1_r; ns_nxt = s0_r;
        end else begin
          n_nxt = p1_r - p0_r; ns_nxt = s1_r;
        end
        if (n_nxt == '0) ns_nxt = 1'b0;
        u_nxt = n_nxt;
        v_nxt = d_r;
        k_nxt = '0;
      end
      S_GCD: begin
        // Binary gcd, one step per cycle.
        if (gcd_done) begin
          g_nxt   = v_r << k_r;
          rem_nxt = '0;
          q_nxt   = n_r;
          cnt_nxt = '0;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1; v_nxt = v_r >> 1; k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r >= v_r) begin
          u_nxt = u_r - v_r;
        end else begin
          v_nxt = v_r - u_r;
        end
      end
      S_DIVN, S_DIVD: begin
        rem_nxt = q_bit ? PROD_W'(rem_sh - {1'b0, g_r}) : rem_sh[PROD_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          cnt_nxt = '0;
          if (st_r == S_DIVN) begin
            n_nxt   = q_nxt;
            rem_nxt = '0;
            q_nxt   = d_r;
          end else if (ovf) begin
            res_nxt = '{res_num: '0, res_den: '0, status: STAT_OVF};
          end else begin
            res_nxt.res_num = neg ? -(32'(n_r)) : 32'(n_r);
            res_nxt.res_den = 31'(q_nxt);
            res_nxt.status  = STAT_OK;
          end
        end
      end
      S_FIN: begin
        if (out_free) ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Payload registers; the output word has its own holding register below.
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    s0_r   <= s0_nxt;
    s1_r   <= s1_nxt;
    n_r    <= n_nxt;
    ns_r   <= ns_nxt;
    d_r    <= d_nxt;
    ds_r   <= ds_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    g_r    <= g_nxt;
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    res_r  <= res_nxt;
  end

  // Output holding register, loaded as a result leaves the final state.
  rau_out_t out_r;
  always_ff @(posedge clk) begin
    if (st_r == S_FIN && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_gcd_v_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_GCD) |-> (v_r != '0))
    else $error("gcd operand went to zero");

  a_div_g_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIVN) |-> (g_r != '0))
    else $error("divider started with zero divisor");

  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_OK) |-> (out_data.res_den != '0))
    else $error("ok result with zero denominator");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (st_r == S_MUL || st_r == S_FIN))
    else $error("job taken without starting work");

endmodule

// ----- rtl/core/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides or normalizes fractions with gcd
// reduction. A front classifies words into a two-entry queue; a back unit
// works them out one at a time.
// ----------------------------------------------------------------------------
//  Channel | Ports                          | Word
//  --------+--------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_data    | cmd, a_num, a_den, b_num, b_den
//  result  | out_valid, out_ready, out_data | res_num, res_den, status
//
// An item passes through the back unit's products, signed sum, binary gcd loop (one step
// per cycle) and the shared restoring divider, which forms the numerator quotient and
// then the denominator quotient; error items go straight to the final state.
// Reset is synchronous and active low and empties the queue and the output.
// The input is taken while the queue has room, also while a result waits.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  rau_job_t job_in, job_out;
  logic     q_full, q_empty, q_pop;

  rau_front u_front (
    .in_data (in_data),
    .job     (job_in)
  );

  rau_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (job_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (job_out),
    .empty     (q_empty)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job_data  (job_out),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = !q_full;

endmodule

// ----- test/rational_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Self-checking bench for the rational arithmetic unit. Directed words cover
// the field extremes, every operation and the error cases; random words then
// mix small and full-range fractions. Each result word is checked against a
// local fraction predictor in arrival order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int N_RANDOM     = 500;
  localparam int TAIL_WORDS   = 60;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int END_WAIT     = 500;
  localparam int STALL_CYCLES = 3000;
  localparam logic [2:0] CMD_NORM = 3'd4;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  rau_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rau_out_t out_data;

  rau_in_t  pending_words[$];
  rau_out_t expected_results[$];
  int       n_errors = 0;
  int       n_checked = 0;
  int       n_sent = 0;
  int       n_status[3] = '{0, 0, 0};
  int       cycle_count = 0;
  bit       stim_done;
  bit       quiet_mode;
  bit       sender_hold;
  bit       stall_start;
  bit       stall_hold;
  bit       stall_done;
  int       in_gap;
  int       out_gap;

  rational_arithmetic_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock; the single reset is driven by the stimulus below.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Split a field into sign and magnitude.
  function automatic logic [64:0] to_sign_mag(input logic [31:0] raw);
    logic neg;
    neg = raw[31];
    return {neg, 32'd0, (neg ? (~raw + 32'd1) : raw)};
  endfunction

  // Exact rational result of one word, reduced by Euclid's gcd.
  function automatic rau_out_t compute_fraction(input rau_in_t w);
    logic [64:0] an, ad, bn, bd, p, q, r;
    logic [63:0] nm, dm, x, y, t, g, half;
    logic        nn, dn, neg, bneg;
    rau_out_t    res;
    an = to_sign_mag(w.a_num);
    ad = to_sign_mag(w.a_den);
    bn = to_sign_mag(w.b_num);
    bd = to_sign_mag(w.b_den);
    res = '{res_num: '0, res_den: '0, status: STAT_DIVZ};
    if (ad[63:0] == 0 || (w.cmd <= CMD_DIV && bd[63:0] == 0) ||
        (w.cmd == CMD_DIV && bn[63:0] == 0)) begin
      return res;
    end
    case (w.cmd)
      CMD_ADD, CMD_SUB: begin
        bneg = bn[64];
        if (w.cmd == CMD_SUB) bneg = !bneg && bn[63:0] != 0;
        p = {an[64] != bd[64], an[63:0] * bd[63:0]};
        q = {bneg != ad[64], bn[63:0] * ad[63:0]};
        if (p[64] == q[64]) r = {p[64], p[63:0] + q[63:0]};
        else if (p[63:0] >= q[63:0]) r = {p[64], p[63:0] - q[63:0]};
        else r = {q[64], q[63:0] - p[63:0]};
        nm = r[63:0]; nn = r[64] && nm != 0;
        dm = ad[63:0] * bd[63:0]; dn = ad[64] != bd[64];
      end
      CMD_MUL: begin
        nm = an[63:0] * bn[63:0]; nn = an[64] != bn[64];
        dm = ad[63:0] * bd[63:0]; dn = ad[64] != bd[64];
      end
      CMD_DIV: begin
        nm = an[63:0] * bd[63:0]; nn = an[64] != bd[64];
        dm = ad[63:0] * bn[63:0]; dn = ad[64] != bn[64];
      end
      default: begin
        nm = an[63:0]; nn = an[64];
        dm = ad[63:0]; dn = ad[64];
      end
    endcase
    x = nm; y = dm;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    g = (x == 0) ? 64'd1 : x;
    nm = nm / g; dm = dm / g;
    neg = (nn != dn) && nm != 0;
    half = 64'd1 << 31;
    if (dm > half - 1 || (neg ? nm > half : nm > half - 1)) begin
      res.status = STAT_OVF;
      return res;
    end
    res.res_num = neg ? (32'd0 - nm[31:0]) : nm[31:0];
    res.res_den = dm[30:0];
    res.status  = STAT_OK;
    return res;
  endfunction

  // A random field value: often small, sometimes any 32-bit pattern.
  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4:       return 32'd0;
      5, 6:    return 32'd0 - $urandom_range(1, 1000);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  task automatic add_word(input logic [2:0] c, input logic [31:0] an, input logic [31:0] ad,
                          input logic [31:0] bn, input logic [31:0] bd);
    rau_in_t w;
    w = '{cmd: c, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    pending_words.push_back(w);
  endtask

  // Stimulus: directed words, a long output stall, a drain pause, then random words.
  initial begin
    rst_n = 1'b0;
    stim_done = 1'b0;
    sender_hold = 1'b0;
    quiet_mode = 1'b0;
    stall_start = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_word(CMD_ADD, 1, 2, 1, 3);
    add_word(CMD_SUB, 1, 2, 1, 2);
    add_word(CMD_MUL, -3, 4, 2, -9);
    add_word(CMD_DIV, 3, 4, -6, 8);
    add_word(CMD_NORM, -6, -4, 0, 0);
    add_word(3'd5, 10, -20, 1, 1);
    add_word(3'd6, 0, 7, 5, 5);
    add_word(3'd7, 32'h8000_0000, 1, 0, 0);
    add_word(CMD_ADD, 1, 0, 1, 1);
    add_word(CMD_MUL, 1, 1, 1, 0);
    add_word(CMD_DIV, 1, 1, 0, 5);
    add_word(CMD_NORM, 5, 0, 1, 0);
    add_word(CMD_NORM, 1, 32'h8000_0000, 0, 0);
    add_word(CMD_NORM, 32'h8000_0000, -1, 0, 0);
    add_word(CMD_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    add_word(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    add_word(CMD_SUB, 32'h8000_0000, 1, 1, 1);
    add_word(CMD_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_word(CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_word(CMD_ADD, 0, 5, 0, -3);
    add_word(CMD_SUB, 32'h5555_5555, 32'haaaa_aaab, 32'haaaa_aaaa, 32'h5555_5555);
    add_word(CMD_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);

    // Hold the receiver off while the sender keeps offering, so the block fills.
    stall_start = 1'b1;
    wait (stall_hold);
    for (int i = 0; i < 12; i++) add_word(CMD_MUL, i + 1, 7, 3, i + 2);
    wait (stall_done);

    // Let everything drain before more words go out.
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    sender_hold = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    sender_hold = 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      add_word(3'($urandom_range(0, 7)), rand_field(), rand_field(), rand_field(),
               rand_field());
      if (i == N_RANDOM - TAIL_WORDS) begin
        while (pending_words.size() != 0) @(posedge clk);
        quiet_mode = 1'b1;
      end
    end
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    stim_done = 1'b1;
  end

  // Long receiver stall, counted here once the stimulus asks for it.
  initial begin
    stall_hold = 1'b0;
    stall_done = 1'b0;
    wait (stall_start);
    @(posedge clk);
    stall_hold = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    stall_hold = 1'b0;
    stall_done = 1'b1;
  end

  // Driver: present the next pending word, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else if (in_valid && !in_ready) begin
      // Hold the word until it is taken.
    end else begin
      if (in_valid) begin
        expected_results.push_back(compute_fraction(in_data));
        n_sent++;
      end
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 && !sender_hold) begin
        in_valid <= 1'b1;
        in_data  <= pending_words.pop_front();
        if (!quiet_mode && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    rau_out_t exp_word;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %p", out_data);
          n_errors++;
        end else begin
          exp_word = expected_results.pop_front();
          n_checked++;
          if (exp_word.status <= STAT_OVF) n_status[exp_word.status]++;
          if (out_data.res_num !== exp_word.res_num) begin
            $error("res_num: expected %0d, actual %0d", exp_word.res_num, out_data.res_num);
            n_errors++;
          end
          if (out_data.res_den !== exp_word.res_den) begin
            $error("res_den: expected %0d, actual %0d", exp_word.res_den, out_data.res_den);
            n_errors++;
          end
          if (out_data.status !== exp_word.status) begin
            $error("status: expected %0d, actual %0d", exp_word.status, out_data.status);
            n_errors++;
          end
        end
      end
      if (stall_hold) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_mode && $urandom_range(0, 4) == 0) out_gap <= $urandom_range(1, 7);
      end
    end
  end

  // Cycle limit: the run fails if it has not finished by CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("rational_arithmetic_unit regression: fail");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    $display("checked %0d of %0d words across all five operations and unused codes",
             n_checked, n_sent);
    $display("status counts: ok %0d, divide by zero %0d, overflow %0d",
             n_status[0], n_status[1], n_status[2]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end

endmodule
